// File: src/abbc_pkg.sv
// Shared types and constants of the alpha bounding-box crop block.
package abbc_pkg;

    localparam int DIM_CFG_W   = 13;
    localparam int ALPHA_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CROP_POS_W  = 12;
    localparam int CROP_LEN_W  = 13;
    localparam int MAX_DIM_DEF = 4096;
    localparam logic [2*DIM_CFG_W-1:0] PIXEL_LIMIT = (2*DIM_CFG_W)'(4194304);

    localparam logic [DIM_CFG_W-1:0] RST_FRAME_W   = DIM_CFG_W'(4096);
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_H   = DIM_CFG_W'(4096);
    localparam logic [ALPHA_W-1:0]   RST_THRESHOLD = ALPHA_W'(8);
    localparam logic                 RST_TRIM      = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_ALPHA_THRESHOLD,
        REG_TRIM_MARGINS
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OPAQUE,
        ST_EMPTY,
        ST_TOO_LARGE
    } t_status;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] width;
        logic [DIM_CFG_W-1:0] height;
        logic [ALPHA_W-1:0]   threshold;
        logic                 trim;
        logic                 size_ok;
    } t_cfg;

    typedef struct packed {
        logic                 bad_size;
        logic                 saw_transparent;
        logic [DIM_CFG_W-1:0] box_left;
        logic [DIM_CFG_W-1:0] box_top;
        logic [DIM_CFG_W-1:0] box_right;
        logic [DIM_CFG_W-1:0] box_bottom;
    } t_frame_sum;

endpackage

// File: src/abbc_track.sv
// Pixel input register, raster counters and bounding-box tracking.
module abbc_track #(
    parameter int MAX_DIM = abbc_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  abbc_pkg::t_cfg                i_cfg,
    input  logic [abbc_pkg::DIM_CFG_W-1:0] i_start_width,
    input  logic [abbc_pkg::DIM_CFG_W-1:0] i_start_height,
    input  logic                          i_restart,
    input  logic                          i_valid,
    input  logic [abbc_pkg::ALPHA_W-1:0]  i_alpha,
    output logic                          o_stall,
    output logic                          o_sum_valid,
    output abbc_pkg::t_frame_sum          o_sum,
    input  logic                          i_sum_ready
);
    import abbc_pkg::*;

    localparam int DIM_W = ($clog2(MAX_DIM + 1) < DIM_CFG_W) ? $clog2(MAX_DIM + 1) : DIM_CFG_W;
    localparam int CMP_W = DIM_CFG_W + 1;

    logic               r_pix_valid;
    logic [ALPHA_W-1:0] r_alpha;
    logic [DIM_W-1:0]   r_column;
    logic [DIM_W-1:0]   r_row;
    logic [DIM_W-1:0]   r_box_left;
    logic [DIM_W-1:0]   r_box_top;
    logic [DIM_W-1:0]   r_box_right;
    logic [DIM_W-1:0]   r_box_bottom;
    logic               r_saw;
    logic               r_sum_valid;
    t_frame_sum         r_sum;

    logic               adv;
    logic               step;
    logic               visible;
    logic [DIM_W:0]     col_nx;
    logic [DIM_W:0]     row_nx;
    logic               col_last;
    logic               row_last;
    logic               frame_last;
    logic [DIM_W-1:0]   n_box_left;
    logic [DIM_W-1:0]   n_box_top;
    logic [DIM_W-1:0]   n_box_right;
    logic [DIM_W-1:0]   n_box_bottom;
    logic               n_saw;
    t_frame_sum         n_sum;

    assign adv     = !r_sum_valid || i_sum_ready;
    assign step    = r_pix_valid && adv;
    assign o_stall = r_pix_valid && !adv;

    always_comb begin
        col_nx     = {1'b0, r_column} + (DIM_W + 1)'(1);
        row_nx     = {1'b0, r_row} + (DIM_W + 1)'(1);
        col_last   = !(CMP_W'(col_nx) < CMP_W'(i_cfg.width));
        row_last   = !(CMP_W'(row_nx) < CMP_W'(i_cfg.height));
        frame_last = col_last && row_last;
        visible    = r_alpha >= i_cfg.threshold;
        n_saw      = r_saw || (r_alpha == '0);

        n_box_left   = r_box_left;
        n_box_top    = r_box_top;
        n_box_right  = r_box_right;
        n_box_bottom = r_box_bottom;
        if (visible) begin
            if (r_column < r_box_left) begin
                n_box_left = r_column;
            end
            if (r_row < r_box_top) begin
                n_box_top = r_row;
            end
            if (col_nx > {1'b0, r_box_right}) begin
                n_box_right = col_nx[DIM_W-1:0];
            end
            if (row_nx > {1'b0, r_box_bottom}) begin
                n_box_bottom = row_nx[DIM_W-1:0];
            end
        end

        n_sum.bad_size        = !i_cfg.size_ok;
        n_sum.saw_transparent = n_saw;
        n_sum.box_left        = DIM_CFG_W'(n_box_left);
        n_sum.box_top         = DIM_CFG_W'(n_box_top);
        n_sum.box_right       = DIM_CFG_W'(n_box_right);
        n_sum.box_bottom      = DIM_CFG_W'(n_box_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid  <= 1'b0;
            r_sum_valid  <= 1'b0;
            r_column     <= '0;
            r_row        <= '0;
            r_box_left   <= DIM_W'(RST_FRAME_W);
            r_box_top    <= DIM_W'(RST_FRAME_H);
            r_box_right  <= '0;
            r_box_bottom <= '0;
            r_saw        <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_pix_valid <= i_valid;
            end
            if (adv) begin
                r_sum_valid <= step && (!i_cfg.size_ok || frame_last);
            end
            if (i_restart || (step && i_cfg.size_ok && frame_last)) begin
                r_column     <= '0;
                r_row        <= '0;
                r_box_left   <= DIM_W'(i_start_width);
                r_box_top    <= DIM_W'(i_start_height);
                r_box_right  <= '0;
                r_box_bottom <= '0;
                r_saw        <= 1'b0;
            end else if (step && i_cfg.size_ok) begin
                r_column     <= col_last ? '0 : col_nx[DIM_W-1:0];
                r_row        <= col_last ? row_nx[DIM_W-1:0] : r_row;
                r_box_left   <= n_box_left;
                r_box_top    <= n_box_top;
                r_box_right  <= n_box_right;
                r_box_bottom <= n_box_bottom;
                r_saw        <= n_saw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_alpha <= i_alpha;
        end
        if (adv) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

    a_column_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.size_ok |-> (CMP_W'(r_column) < CMP_W'(i_cfg.width)))
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.size_ok |-> (CMP_W'(r_row) < CMP_W'(i_cfg.height)))
        else $error("row counter beyond frame height");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_valid && !i_sum_ready) |=> (r_sum_valid && $stable(r_sum)))
        else $error("frame summary changed while held");

endmodule

// File: src/abbc_result.sv
// Crop rectangle and status from a frame summary, with the output register.
module abbc_result (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  abbc_pkg::t_cfg                   i_cfg,
    input  logic                             i_sum_valid,
    input  abbc_pkg::t_frame_sum             i_sum,
    output logic                             o_sum_ready,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic [abbc_pkg::CROP_POS_W-1:0]  o_crop_left,
    output logic [abbc_pkg::CROP_POS_W-1:0]  o_crop_top,
    output logic [abbc_pkg::CROP_LEN_W-1:0]  o_crop_width,
    output logic [abbc_pkg::CROP_LEN_W-1:0]  o_crop_height
);
    import abbc_pkg::*;

    localparam int AW = DIM_CFG_W + 1;

    logic                  r_valid;
    t_status               r_status;
    logic [CROP_POS_W-1:0] r_left;
    logic [CROP_POS_W-1:0] r_top;
    logic [CROP_LEN_W-1:0] r_width;
    logic [CROP_LEN_W-1:0] r_height;

    t_status               n_status;
    logic [AW-1:0]         l;
    logic [AW-1:0]         t;
    logic [AW-1:0]         r;
    logic [AW-1:0]         b;
    logic [AW-1:0]         n_left;
    logic [AW-1:0]         n_top;
    logic [AW-1:0]         n_width;
    logic [AW-1:0]         n_height;

    assign o_sum_ready = !r_valid || !i_stall;

    always_comb begin
        l = (i_sum.box_left != '0) ? AW'(i_sum.box_left) - AW'(1) : '0;
        t = (i_sum.box_top != '0) ? AW'(i_sum.box_top) - AW'(1) : '0;
        r = AW'(i_sum.box_right) + AW'(1);
        b = AW'(i_sum.box_bottom) + AW'(1);
        if (r > AW'(i_cfg.width)) begin
            r = AW'(i_cfg.width);
        end
        if (b > AW'(i_cfg.height)) begin
            b = AW'(i_cfg.height);
        end

        n_status = ST_OK;
        n_left   = '0;
        n_top    = '0;
        n_width  = '0;
        n_height = '0;
        priority if (i_sum.bad_size) begin
            n_status = ST_TOO_LARGE;
        end else if (!i_sum.saw_transparent) begin
            n_status = ST_OPAQUE;
        end else if ((i_sum.box_left >= i_sum.box_right) ||
                     (i_sum.box_top >= i_sum.box_bottom)) begin
            n_status = ST_EMPTY;
        end else if (!i_cfg.trim) begin
            n_width  = AW'(i_cfg.width);
            n_height = AW'(i_cfg.height);
        end else begin
            n_left   = l;
            n_top    = t;
            n_width  = r - l;
            n_height = b - t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_sum_ready) begin
            r_valid <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sum_ready && i_sum_valid) begin
            r_status <= n_status;
            r_left   <= n_left[CROP_POS_W-1:0];
            r_top    <= n_top[CROP_POS_W-1:0];
            r_width  <= n_width[CROP_LEN_W-1:0];
            r_height <= n_height[CROP_LEN_W-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_crop_left   = r_left;
    assign o_crop_top    = r_top;
    assign o_crop_width  = r_width;
    assign o_crop_height = r_height;

    a_error_zero_crop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != ST_OK)) |->
        ((r_left == '0) && (r_top == '0) && (r_width == '0) && (r_height == '0)))
        else $error("crop fields not zero on error status");

    a_crop_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_OK)) |->
        ((AW'(r_left) + AW'(r_width) <= AW'(i_cfg.width)) && (r_width != '0)))
        else $error("crop rectangle outside frame");

    a_too_large_only_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_TOO_LARGE)) |-> !i_cfg.size_ok)
        else $error("size error reported for a valid frame size");

endmodule

// File: src/alpha_bounding_box_crop.sv
// Alpha bounding-box crop: top level with configuration registers.
// Takes one alpha beat per cycle in raster order and returns one result beat
// after the last pixel of each frame (width x height beats). A pixel beat is
// held in an input register, the tracking stage registers the frame summary and
// the output register holds the crop. A new beat is accepted every cycle unless
// results back up behind a stalled output. A frame size of zero, above MAX_DIM
// or of more than 4194304 pixels turns every beat into a status 3 result; the
// reset size of 4096 x 4096 is such a size, so write the frame size first. Any
// configuration write restarts the frame; write only while no beat is in flight.
module alpha_bounding_box_crop #(
    parameter int MAX_DIM = abbc_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [abbc_pkg::ALPHA_W-1:0]     i_alpha,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic [abbc_pkg::CROP_POS_W-1:0]  o_crop_left,
    output logic [abbc_pkg::CROP_POS_W-1:0]  o_crop_top,
    output logic [abbc_pkg::CROP_LEN_W-1:0]  o_crop_width,
    output logic [abbc_pkg::CROP_LEN_W-1:0]  o_crop_height,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [abbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [abbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import abbc_pkg::*;

    localparam logic [DIM_CFG_W+1:0] MAX_DIM_V = (DIM_CFG_W + 2)'(MAX_DIM);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       cfg_wr;
    logic       sum_valid;
    logic       sum_ready;
    t_frame_sum sum;

    function automatic logic size_check(input logic [DIM_CFG_W-1:0] w,
                                        input logic [DIM_CFG_W-1:0] h);
        logic [2*DIM_CFG_W-1:0] prod;
        prod = (2*DIM_CFG_W)'(w) * (2*DIM_CFG_W)'(h);
        return (w != '0) && (h != '0) &&
               ({2'b0, w} <= MAX_DIM_V) && ({2'b0, h} <= MAX_DIM_V) &&
               (prod <= PIXEL_LIMIT);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:     n_cfg.width     = i_cfg_data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT:    n_cfg.height    = i_cfg_data[DIM_CFG_W-1:0];
                REG_ALPHA_THRESHOLD: n_cfg.threshold = i_cfg_data[ALPHA_W-1:0];
                REG_TRIM_MARGINS:    n_cfg.trim      = i_cfg_data[0];
            endcase
        end
        n_cfg.size_ok = size_check(n_cfg.width, n_cfg.height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width:     RST_FRAME_W,
                       height:    RST_FRAME_H,
                       threshold: RST_THRESHOLD,
                       trim:      RST_TRIM,
                       size_ok:   size_check(RST_FRAME_W, RST_FRAME_H)};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    abbc_track #(
        .MAX_DIM (MAX_DIM)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start_width  (n_cfg.width),
        .i_start_height (n_cfg.height),
        .i_restart      (cfg_wr),
        .i_valid        (i_valid),
        .i_alpha        (i_alpha),
        .o_stall        (o_stall),
        .o_sum_valid    (sum_valid),
        .o_sum          (sum),
        .i_sum_ready    (sum_ready)
    );

    abbc_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_sum_valid   (sum_valid),
        .i_sum         (sum),
        .o_sum_ready   (sum_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_crop_left   (o_crop_left),
        .o_crop_top    (o_crop_top),
        .o_crop_width  (o_crop_width),
        .o_crop_height (o_crop_height)
    );

endmodule

// File: test/tb_alpha_bounding_box_crop.sv
// Testbench for the alpha bounding-box crop: directed and random frames checked against a behavioural predictor.
module tb_alpha_bounding_box_crop;
    import abbc_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 800;

    typedef struct {
        t_status               status;
        logic [CROP_POS_W-1:0] left;
        logic [CROP_POS_W-1:0] top;
        logic [CROP_LEN_W-1:0] width;
        logic [CROP_LEN_W-1:0] height;
    } t_crop;

    typedef enum int {
        FR_MIXED,
        FR_OPAQUE,
        FR_FAINT,
        FR_SPARSE
    } t_frame_style;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [ALPHA_W-1:0]    i_alpha     = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [1:0]            o_status;
    logic [CROP_POS_W-1:0] o_crop_left;
    logic [CROP_POS_W-1:0] o_crop_top;
    logic [CROP_LEN_W-1:0] o_crop_width;
    logic [CROP_LEN_W-1:0] o_crop_height;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    alpha_bounding_box_crop dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_alpha       (i_alpha),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_crop_left   (o_crop_left),
        .o_crop_top    (o_crop_top),
        .o_crop_width  (o_crop_width),
        .o_crop_height (o_crop_height),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of registers and frame state
    logic [DIM_CFG_W-1:0]  cfg_w    = RST_FRAME_W;
    logic [DIM_CFG_W-1:0]  cfg_h    = RST_FRAME_H;
    logic [ALPHA_W-1:0]    cfg_thr  = RST_THRESHOLD;
    logic                  cfg_trim = RST_TRIM;
    logic [CROP_POS_W-1:0] px_col   = '0;
    logic [CROP_POS_W-1:0] px_row   = '0;
    logic [DIM_CFG_W-1:0]  box_l    = RST_FRAME_W;
    logic [DIM_CFG_W-1:0]  box_t    = RST_FRAME_H;
    logic [DIM_CFG_W-1:0]  box_r    = '0;
    logic [DIM_CFG_W-1:0]  box_b    = '0;
    logic                  saw_clear = 1'b0;

    logic [ALPHA_W-1:0] pixel_q[$];
    t_crop              crop_q[$];

    int items_queued  = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 58;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void restart_frame();
        px_col    = '0;
        px_row    = '0;
        box_l     = cfg_w;
        box_t     = cfg_h;
        box_r     = '0;
        box_b     = '0;
        saw_clear = 1'b0;
    endfunction

    function automatic bit frame_size_ok();
        if (cfg_w == 0 || cfg_h == 0) return 1'b0;
        if (cfg_w > MAX_DIM || cfg_h > MAX_DIM) return 1'b0;
        return (longint'(cfg_w) * longint'(cfg_h)) <= longint'(PIXEL_LIMIT);
    endfunction

    function automatic void track_pixel(input logic [ALPHA_W-1:0] alpha);
        t_crop                res;
        logic [DIM_CFG_W-1:0] col_nx;
        logic [DIM_CFG_W-1:0] row_nx;
        logic [DIM_CFG_W-1:0] l;
        logic [DIM_CFG_W-1:0] t;
        logic [DIM_CFG_W-1:0] r;
        logic [DIM_CFG_W-1:0] b;
        res = '{ST_TOO_LARGE, '0, '0, '0, '0};
        if (!frame_size_ok()) begin
            crop_q.push_back(res);
            return;
        end
        col_nx = {1'b0, px_col} + 13'd1;
        row_nx = {1'b0, px_row} + 13'd1;
        if (alpha == '0) saw_clear = 1'b1;
        if (alpha >= cfg_thr) begin
            if ({1'b0, px_col} < box_l) box_l = {1'b0, px_col};
            if ({1'b0, px_row} < box_t) box_t = {1'b0, px_row};
            if (col_nx > box_r) box_r = col_nx;
            if (row_nx > box_b) box_b = row_nx;
        end
        if (col_nx < cfg_w) begin
            px_col = col_nx[CROP_POS_W-1:0];
            return;
        end
        px_col = '0;
        if (row_nx < cfg_h) begin
            px_row = row_nx[CROP_POS_W-1:0];
            return;
        end
        if (!saw_clear) begin
            res.status = ST_OPAQUE;
        end else if (box_l >= box_r || box_t >= box_b) begin
            res.status = ST_EMPTY;
        end else if (!cfg_trim) begin
            res.status = ST_OK;
            res.width  = cfg_w;
            res.height = cfg_h;
        end else begin
            l = (box_l != 0) ? box_l - 13'd1 : 13'd0;
            t = (box_t != 0) ? box_t - 13'd1 : 13'd0;
            r = box_r + 13'd1;
            if (r > cfg_w) r = cfg_w;
            b = box_b + 13'd1;
            if (b > cfg_h) b = cfg_h;
            res.status = ST_OK;
            res.left   = l[CROP_POS_W-1:0];
            res.top    = t[CROP_POS_W-1:0];
            res.width  = r - l;
            res.height = b - t;
        end
        crop_q.push_back(res);
        restart_frame();
    endfunction

    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // driver: hold a stalled beat, otherwise advance from the pending queue
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            track_pixel(i_alpha);
            beats_taken++;
        end
        if (!i_valid || !o_stall) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_alpha <= pixel_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_crop want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (crop_q.size() == 0) begin
                $error("result beat with nothing expected: status %0d", o_status);
                mismatches++;
            end else begin
                want = crop_q.pop_front();
                check_field("status", 13'(want.status), 13'(o_status));
                check_field("crop_left", 13'(want.left), 13'(o_crop_left));
                check_field("crop_top", 13'(want.top), 13'(o_crop_top));
                check_field("crop_width", want.width, o_crop_width);
                check_field("crop_height", want.height, o_crop_height);
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, crop_q.size());
            $display("tb_alpha_bounding_box_crop failed");
            $finish;
        end
    end

    task automatic push_pixel(input logic [ALPHA_W-1:0] a);
        pixel_q.push_back(a);
        items_queued++;
    endtask

    task automatic settle();
        while (beats_taken != items_queued || crop_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:     cfg_w    = data;
            REG_FRAME_HEIGHT:    cfg_h    = data;
            REG_ALPHA_THRESHOLD: cfg_thr  = data[ALPHA_W-1:0];
            REG_TRIM_MARGINS:    cfg_trim = data[0];
            default: ;
        endcase
        restart_frame();
        reg_writes++;
    endtask

    // write all four registers, starting at a random one; spare data bits random
    task automatic write_cfg(input int w, input int h, input int thr, input bit trim);
        int       first;
        t_reg_idx idx;
        first = $urandom_range(3);
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'((first + k) % 4);
            case (idx)
                REG_FRAME_WIDTH:     write_reg(idx, 13'(w));
                REG_FRAME_HEIGHT:    write_reg(idx, 13'(h));
                REG_ALPHA_THRESHOLD: write_reg(idx, {5'($urandom), 8'(thr)});
                default:             write_reg(idx, {12'($urandom), trim});
            endcase
        end
    endtask

    task automatic queue_frame(input int w, input int h, input t_frame_style style);
        int                 n;
        int                 hot1;
        int                 hot2;
        logic [ALPHA_W-1:0] a;
        n    = w * h;
        hot1 = $urandom_range(n - 1);
        hot2 = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            case (style)
                FR_MIXED: begin
                    case ($urandom_range(3))
                        0:       a = '0;
                        1:       a = '1;
                        2:       a = cfg_thr + 8'($urandom_range(2)) - 8'd1;
                        default: a = 8'($urandom);
                    endcase
                end
                FR_OPAQUE: a = 8'($urandom_range(255, 1));
                FR_FAINT: begin
                    if (cfg_thr == 0 || i == hot1) a = '0;
                    else a = 8'($urandom_range(cfg_thr - 1));
                end
                default: begin
                    if (i == hot1 || i == hot2) a = 8'($urandom_range(255, cfg_thr));
                    else a = '0;
                end
            endcase
            push_pixel(a);
        end
    endtask

    initial begin
        int                 base;
        int                 rnd_items;
        int                 w;
        int                 h;
        int                 thr;
        int                 frames;
        int                 pick;
        bit                 trim;
        t_frame_style       style;
        logic [ALPHA_W-1:0] mix_px [6];

        restart_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size and other bad sizes (too wide, zero, too many pixels): every beat reports too large
        push_pixel(8'd0);
        push_pixel(8'd255);
        settle();
        write_cfg(8191, 1, 8, 1'b1);
        push_pixel(8'd8);
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd0);
        push_pixel(8'd1);
        settle();
        write_cfg(4096, 1025, 8, 1'b1);
        push_pixel(8'd128);
        settle();

        // single pixel frames: threshold zero, opaque, both faults, empty
        write_cfg(1, 1, 0, 1'b1);
        push_pixel(8'd0);
        settle();
        write_reg(REG_ALPHA_THRESHOLD, 13'd8);
        push_pixel(8'd255);
        push_pixel(8'd7);
        push_pixel(8'd0);
        settle();

        // full frame without trimming, then a broken frame restarted by a write and a trimmed frame
        write_cfg(3, 2, 8, 1'b0);
        mix_px = '{8'd0, 8'd9, 8'd8, 8'd7, 8'd1, 8'd200};
        foreach (mix_px[i])
            push_pixel(mix_px[i]);
        push_pixel(8'd0);
        push_pixel(8'd0);
        settle();
        write_cfg(3, 2, 255, 1'b1);
        push_pixel(8'd255);
        repeat (5) push_pixel(8'd0);
        settle();

        // long single-row and single-column frames
        write_cfg(256, 1, 8, 1'b1);
        for (int i = 0; i < 256; i++) push_pixel((i == 0 || i == 255) ? 8'd255 : 8'd0);
        settle();
        write_cfg(1, 256, 200, 1'b1);
        for (int i = 0; i < 256; i++) push_pixel((i == 255) ? 8'd201 : 8'd0);
        settle();

        base      = items_queued;
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            if (rnd_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 58;
            end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(5))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = 1;
                default: thr = $urandom_range(255);
            endcase
            trim = $urandom_range(1);
            pick = $urandom_range(99);
            if (pick < 7) begin
                case ($urandom_range(3))
                    0: begin
                        w = $urandom_range(8191, 4097);
                        h = $urandom_range(8, 1);
                    end
                    1: begin
                        w = $urandom_range(8, 1);
                        h = $urandom_range(8191, 4097);
                    end
                    2: begin
                        w = $urandom_range(1) ? 0 : $urandom_range(8191);
                        h = (w == 0) ? $urandom_range(8191) : 0;
                    end
                    default: begin
                        w = 4096;
                        h = $urandom_range(4096, 1025);
                    end
                endcase
                write_cfg(w, h, thr, trim);
                repeat ($urandom_range(4, 1)) push_pixel(8'($urandom));
            end else begin
                w = (pick < 14) ? 1 : $urandom_range(8, 1);
                h = (pick >= 14 && pick < 20) ? 1 : $urandom_range(6, 1);
                write_cfg(w, h, thr, trim);
                frames = $urandom_range(5, 1);
                repeat (frames) begin
                    pick = $urandom_range(99);
                    if (pick < 50) style = FR_MIXED;
                    else if (pick < 75) style = FR_SPARSE;
                    else if (pick < 87) style = FR_OPAQUE;
                    else style = FR_FAINT;
                    queue_frame(w, h, style);
                end
                if (w * h > 1 && $urandom_range(99) < 12)
                    repeat ($urandom_range(w * h - 1, 1)) push_pixel(8'($urandom));
            end
            rnd_items = items_queued - base;
            settle();
        end

        settle();
        $display("%0d pixel beats accepted, %0d register writes, %0d result beats checked",
                 beats_taken, reg_writes, results_seen);
        $display("frames from 1x1 to 256x1 and 1x256, oversize sizes and broken frames");
        if (mismatches == 0) begin
            $display("tb_alpha_bounding_box_crop passed");
        end else begin
            $display("tb_alpha_bounding_box_crop failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/abbc_pkg.sv
src/abbc_track.sv
src/abbc_result.sv
src/alpha_bounding_box_crop.sv
test/tb_alpha_bounding_box_crop.sv
